[rtl/dbbc_pkg.sv]
// Shared constants and types for the dual band biquad cascade.
package dbbc_pkg;

    localparam int NUM_REGS    = 8;
    localparam int COEF_W      = 16;
    localparam int HIST_W      = 32;
    localparam int X_W         = 33;
    localparam int NUM_W       = 49;
    localparam int MAG_W       = 48;
    localparam int REM_W       = 14;
    localparam int GAIN        = 94;
    localparam int DIVISOR     = 9825;
    localparam int OUT_W       = 16;

    // Section order inside one item
    localparam logic [1:0] SEC_LOW1  = 2'd0;
    localparam logic [1:0] SEC_HIGH1 = 2'd1;
    localparam logic [1:0] SEC_LOW2  = 2'd2;
    localparam logic [1:0] SEC_HIGH2 = 2'd3;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [HIST_W-1:0] hist_t;
    typedef logic signed [X_W-1:0]    xval_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sec_status_t;

    function automatic coef_t reg_reset_value(input logic [2:0] idx);
        coef_t v;
        unique case (idx)
            3'd0:    v = -16'sd19039;
            3'd1:    v = 16'sd9865;
            3'd2:    v = -16'sd19119;
            3'd3:    v = 16'sd9871;
            3'd4:    v = -16'sd18646;
            3'd5:    v = 16'sd9865;
            3'd6:    v = -16'sd18740;
            default: v = 16'sd9870;
        endcase
        return v;
    endfunction

endpackage

[rtl/dbbc_section.sv]
// One biquad section evaluator: bit-serial coefficient products, then bit-serial division.
module dbbc_section
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  dbbc_pkg::xval_t       x0,
    input  dbbc_pkg::xval_t       x2,
    input  dbbc_pkg::hist_t       h0,
    input  dbbc_pkg::hist_t       h1,
    input  dbbc_pkg::coef_t       a1,
    input  dbbc_pkg::coef_t       a2,
    output dbbc_pkg::sec_status_t status,
    output dbbc_pkg::hist_t       y
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam int NW = dbbc_pkg::NUM_W;
    localparam int MW = dbbc_pkg::MAG_W;
    localparam int RW = dbbc_pkg::REM_W;
    localparam int X_W_L = dbbc_pkg::X_W + 1;
    localparam logic signed [NW-1:0] GAIN_N = NW'(dbbc_pkg::GAIN);
    localparam logic [RW:0]          DIV_R  = (RW+1)'(dbbc_pkg::DIVISOR);
    localparam logic [MW-1:0]        POS_MAX = MW'(64'h7FFF_FFFF);
    localparam logic [MW-1:0]        NEG_MAX = MW'(64'h8000_0000);

    logic [1:0]                state_reg, state_next;
    logic [5:0]                cnt_reg, cnt_next;
    logic signed [NW-1:0]      p_reg, p_next;
    logic signed [NW-1:0]      g_reg, g_next;
    logic [dbbc_pkg::COEF_W-1:0] a1_sh_reg, a1_sh_next, a2_sh_reg, a2_sh_next;
    dbbc_pkg::hist_t           h0_reg, h0_next, h1_reg, h1_next;
    logic [MW-1:0]             mag_reg, mag_next;
    logic [RW-1:0]             rem_reg, rem_next;
    logic                      neg_reg, neg_next;
    dbbc_pkg::hist_t           y_reg, y_next;

    logic signed [X_W_L-1:0]   diff;
    logic signed [NW-1:0]      term, num;
    logic [RW:0]               trial;

    always_comb
    begin
        diff  = X_W_L'(x0) - X_W_L'(x2);
        term  = (a1_sh_reg[dbbc_pkg::COEF_W-1] ? NW'(h0_reg) : '0)
              + (a2_sh_reg[dbbc_pkg::COEF_W-1] ? NW'(h1_reg) : '0);
        num   = g_reg - ((p_reg <<< 1) + term);
        trial = {rem_reg, mag_reg[MW-1]};
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        p_next     = p_reg;
        g_next     = g_reg;
        a1_sh_next = a1_sh_reg;
        a2_sh_next = a2_sh_reg;
        h0_next    = h0_reg;
        h1_next    = h1_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        y_next     = y_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // sign bits carry negative weight: seed the accumulator with them
                    p_next     = -((a1[dbbc_pkg::COEF_W-1] ? NW'(h0) : NW'(0))
                                 + (a2[dbbc_pkg::COEF_W-1] ? NW'(h1) : NW'(0)));
                    g_next     = NW'(diff) * GAIN_N;
                    a1_sh_next = {a1[dbbc_pkg::COEF_W-2:0], 1'b0};
                    a2_sh_next = {a2[dbbc_pkg::COEF_W-2:0], 1'b0};
                    h0_next    = h0;
                    h1_next    = h1;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                p_next     = (p_reg <<< 1) + term;
                a1_sh_next = {a1_sh_reg[dbbc_pkg::COEF_W-2:0], 1'b0};
                a2_sh_next = {a2_sh_reg[dbbc_pkg::COEF_W-2:0], 1'b0};
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'(dbbc_pkg::COEF_W-2))
                begin
                    neg_next   = num[NW-1];
                    mag_next   = num[NW-1] ? MW'(-num) : MW'(num);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (trial >= DIV_R)
                begin
                    rem_next = RW'(trial - DIV_R);
                    mag_next = {mag_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[RW-1:0];
                    mag_next = {mag_reg[MW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(MW-1))
                begin
                    state_next = ST_OUT;
                end
            end
            default:
            begin
                // saturate the truncated quotient to 32-bit signed
                if (!neg_reg)
                begin
                    y_next = (mag_reg > POS_MAX) ? 32'sh7FFF_FFFF : mag_reg[31:0];
                end
                else
                begin
                    y_next = (mag_reg > NEG_MAX) ? 32'sh8000_0000 : -mag_reg[31:0];
                end
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        g_reg     <= g_next;
        a1_sh_reg <= a1_sh_next;
        a2_sh_reg <= a2_sh_next;
        h0_reg    <= h0_next;
        h1_reg    <= h1_next;
        mag_reg   <= mag_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        y_reg     <= y_next;
    end

    logic out_done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_done_reg <= 1'b0;
        end
        else
        begin
            out_done_reg <= (state_reg == ST_OUT);
        end
    end

    assign status.busy = (state_reg != ST_IDLE) || out_done_reg;
    assign status.done = out_done_reg;
    assign y           = y_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> {1'b0, rem_reg} < DIV_R)
        else $error("remainder reached the divisor");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> cnt_reg < 6'(dbbc_pkg::COEF_W-1))
        else $error("product step count overran");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |=> status.done && state_reg == ST_IDLE)
        else $error("section result not flagged");
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !status.busy)
        else $error("section started while busy");

endmodule

[rtl/dual_band_biquad_cascade.sv]
// Top level of the dual band biquad cascade: stream ports, coefficients, history, sequencing.
//   Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one converter sample per
//   transaction; the low SAMPLE_BITS bits of the 12-bit field are used.
//   Master stream (m_tvalid/m_tready/m_tdata) returns one transaction per
//   sample holding the low band and the high band outputs, each saturated to
//   16-bit signed.
//   The configuration port writes one 16-bit feedback coefficient per cycle
//   when cfg_we is high; indexes past the eighth register are dropped. Write
//   only while the block is idle.
//   The four sections (low 1, high 1, low 2, high 2) run one after another on
//   one shared section unit. Each section has a start step, bit-serial
//   products, bit-serial division by 9825, a saturation step and a step that
//   returns the result; no new sample is taken before the last one is done.
//   s_tready is high only while no sample is in work.
//   When the receiver stalls, the result holds in the output register; the
//   next sample may still be accepted and computed, and it waits at the end
//   of its work until the output register is free.
//   Reset restores the default coefficients and clears all filter history.
module dual_band_biquad_cascade
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample_in, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] low_band_out, [31:16] high_band_out
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [1:0] T_IDLE   = 2'd0;
    localparam logic [1:0] T_START  = 2'd1;
    localparam logic [1:0] T_WAIT   = 2'd2;
    localparam logic [1:0] T_FINISH = 2'd3;

    localparam int XW = dbbc_pkg::X_W;

    logic [1:0]                 state_reg, state_next;
    logic [1:0]                 sec_reg, sec_next;
    logic [SAMPLE_BITS-1:0]     x_reg, x_next;
    logic [SAMPLE_BITS-1:0]     xh0_reg, xh1_reg;
    dbbc_pkg::coef_t            coef_reg [dbbc_pkg::NUM_REGS];
    dbbc_pkg::hist_t            h0_reg [4];
    dbbc_pkg::hist_t            h1_reg [4];
    dbbc_pkg::hist_t            y_reg [4];
    logic                       m_tvalid_reg;
    logic [31:0]                m_tdata_reg;

    logic                       sec_start;
    dbbc_pkg::sec_status_t      sec_status;
    dbbc_pkg::hist_t            sec_y;
    dbbc_pkg::xval_t            sec_x0, sec_x2;
    logic [2:0]                 coef_base;
    logic [15:0]                sample16;
    logic                       commit;

    assign sample16 = {4'b0, s_tdata[11:0]};

    // coefficient pair for a section: low 1 -> 0/1, high 1 -> 4/5, low 2 -> 2/3, high 2 -> 6/7
    assign coef_base = {sec_reg[0], sec_reg[1], 1'b0};

    always_comb
    begin
        unique case (sec_reg)
            dbbc_pkg::SEC_LOW1, dbbc_pkg::SEC_HIGH1:
            begin
                sec_x0 = XW'({1'b0, x_reg});
                sec_x2 = XW'({1'b0, xh1_reg});
            end
            dbbc_pkg::SEC_LOW2:
            begin
                sec_x0 = XW'(y_reg[dbbc_pkg::SEC_LOW1]);
                sec_x2 = XW'(h1_reg[dbbc_pkg::SEC_LOW1]);
            end
            default:
            begin
                sec_x0 = XW'(y_reg[dbbc_pkg::SEC_HIGH1]);
                sec_x2 = XW'(h1_reg[dbbc_pkg::SEC_HIGH1]);
            end
        endcase
    end

    dbbc_section u_section
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sec_start),
        .x0     (sec_x0),
        .x2     (sec_x2),
        .h0     (h0_reg[sec_reg]),
        .h1     (h1_reg[sec_reg]),
        .a1     (coef_reg[coef_base]),
        .a2     (coef_reg[coef_base + 3'd1]),
        .status (sec_status),
        .y      (sec_y)
    );

    function automatic logic [15:0] sat16(input dbbc_pkg::hist_t v);
        logic [15:0] r;
        if (v > 32'sd32767)
        begin
            r = 16'h7FFF;
        end
        else if (v < -32'sd32768)
        begin
            r = 16'h8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        sec_next   = sec_reg;
        x_next     = x_reg;
        sec_start  = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next     = sample16[SAMPLE_BITS-1:0];
                    sec_next   = dbbc_pkg::SEC_LOW1;
                    state_next = T_START;
                end
            end
            T_START:
            begin
                sec_start  = 1'b1;
                state_next = T_WAIT;
            end
            T_WAIT:
            begin
                if (sec_status.done)
                begin
                    if (sec_reg == dbbc_pkg::SEC_HIGH2)
                    begin
                        state_next = T_FINISH;
                    end
                    else
                    begin
                        sec_next   = sec_reg + 2'd1;
                        state_next = T_START;
                    end
                end
            end
            default:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    commit     = 1'b1;
                    state_next = T_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            sec_reg      <= dbbc_pkg::SEC_LOW1;
            m_tvalid_reg <= 1'b0;
            xh0_reg      <= '0;
            xh1_reg      <= '0;
            for (int i = 0; i < 4; i++)
            begin
                h0_reg[i] <= '0;
                h1_reg[i] <= '0;
            end
            for (int i = 0; i < dbbc_pkg::NUM_REGS; i++)
            begin
                coef_reg[i] <= dbbc_pkg::reg_reset_value(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            sec_reg   <= sec_next;
            if (cfg_we && cfg_index < 4'(dbbc_pkg::NUM_REGS))
            begin
                coef_reg[cfg_index[2:0]] <= cfg_data;
            end
            if (commit)
            begin
                // advance all histories at once so the second sections saw the old values
                xh0_reg <= x_reg;
                xh1_reg <= xh0_reg;
                for (int i = 0; i < 4; i++)
                begin
                    h0_reg[i] <= y_reg[i];
                    h1_reg[i] <= h0_reg[i];
                end
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        if (state_reg == T_WAIT && sec_status.done)
        begin
            y_reg[sec_reg] <= sec_y;
        end
        if (commit)
        begin
            m_tdata_reg <= {sat16(y_reg[dbbc_pkg::SEC_HIGH2]), sat16(y_reg[dbbc_pkg::SEC_LOW2])};
        end
    end

    assign s_tready = (state_reg == T_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
